### design/incl_chk_pkg.sv
package incl_chk_pkg;

  // Frame layout and field widths.
  localparam int FrameW = 32;
  localparam int DataW  = 16;
  localparam int OpW    = 8;
  localparam int CrcW   = 8;
  localparam int QtyW   = 4;
  localparam int PosW   = 4;
  localparam int CrcMsgW = FrameW - CrcW;

  // Burst length of the standard read sequence.
  localparam int FramesPerBurstDefault = 12;

  // Reset value of the identity register.
  localparam logic [DataW-1:0] ExpectedIdReset = 16'h00C1;

  // CRC-8 definition.
  localparam logic [CrcW-1:0] CrcPoly = 8'h1D;
  localparam logic [CrcW-1:0] CrcInit = 8'hFF;

  // Return status field and its good code.
  localparam logic [1:0] StatusOk = 2'b01;

  // Quantity codes that do not follow from the frame position, and the last code that does.
  localparam logic [QtyW-1:0] QtyNone    = 4'd0;
  localparam logic [QtyW-1:0] QtyStatus  = 4'd9;
  localparam logic [QtyW-1:0] QtyId      = 4'd10;
  localparam logic [QtyW-1:0] QtyLastRun = 4'd8;

  // One checked response.
  typedef struct packed {
    logic [QtyW-1:0]  quantity;
    logic [DataW-1:0] data_word;
    logic [OpW-1:0]   op_byte;
    logic             crc_error;
    logic             status_error;
    logic             burst_done;
    logic             burst_ok;
  } result_t;

endpackage

### design/incl_frame_if.sv
interface incl_frame_if;
  logic                                valid;
  logic                                ready;
  logic [incl_chk_pkg::FrameW-1:0]     rx_frame;
  logic                                burst_start;

  modport source (output valid, output rx_frame, output burst_start, input ready);
  modport sink   (input valid, input rx_frame, input burst_start, output ready);
endinterface

### design/incl_result_if.sv
interface incl_result_if;
  logic                              valid;
  logic                              ready;
  logic [incl_chk_pkg::QtyW-1:0]     quantity;
  logic [incl_chk_pkg::DataW-1:0]    data_word;
  logic [incl_chk_pkg::OpW-1:0]      op_byte;
  logic                              crc_error;
  logic                              status_error;
  logic                              burst_done;
  logic                              burst_ok;

  modport source (
    output valid, output quantity, output data_word, output op_byte,
    output crc_error, output status_error, output burst_done, output burst_ok,
    input ready
  );
  modport sink (
    input valid, input quantity, input data_word, input op_byte,
    input crc_error, input status_error, input burst_done, input burst_ok,
    output ready
  );
endinterface

### design/incl_chk_crc.sv
module incl_chk_crc (
  input  logic [incl_chk_pkg::CrcMsgW-1:0] msg_i,
  output logic [incl_chk_pkg::CrcW-1:0]    crc_o
);

  logic [incl_chk_pkg::CrcW-1:0] crc;
  logic                          top;

  // Bitwise CRC-8, MSB first; the whole loop folds into a fixed XOR network.
  always_comb begin
    crc = incl_chk_pkg::CrcInit;
    top = 1'b0;
    for (int b = incl_chk_pkg::CrcMsgW - 1; b >= 0; b--) begin
      top = crc[incl_chk_pkg::CrcW-1] ^ msg_i[b];
      crc = {crc[incl_chk_pkg::CrcW-2:0], 1'b0};
      if (top) begin
        crc = crc ^ incl_chk_pkg::CrcPoly;
      end
    end
    crc_o = ~crc;
  end

endmodule

### design/incl_chk_core.sv
module incl_chk_core #(
  parameter int FRAMES_PER_BURST = incl_chk_pkg::FramesPerBurstDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  logic [incl_chk_pkg::FrameW-1:0]   frame_i,
  input  logic                              start_i,
  input  logic [incl_chk_pkg::DataW-1:0]    expected_id_i,
  output incl_chk_pkg::result_t             result_o
);

  localparam logic [incl_chk_pkg::PosW-1:0] LastPos = incl_chk_pkg::PosW'(FRAMES_PER_BURST);
  localparam logic [incl_chk_pkg::PosW-1:0] PrevPos =
    incl_chk_pkg::PosW'(FRAMES_PER_BURST - 1);
  localparam logic [incl_chk_pkg::PosW-1:0] PosOne = incl_chk_pkg::PosW'(1);
  localparam logic [incl_chk_pkg::PosW-1:0] PosTwo = incl_chk_pkg::PosW'(2);

  logic [incl_chk_pkg::PosW-1:0]  pos_q, pos_d;
  logic                           berr_q, berr_d;
  logic [incl_chk_pkg::PosW-1:0]  pos;
  logic [incl_chk_pkg::PosW-1:0]  pos_off;
  logic [incl_chk_pkg::CrcW-1:0]  crc_calc;
  logic [incl_chk_pkg::DataW-1:0] data;
  logic [incl_chk_pkg::OpW-1:0]   op;
  logic                           crc_err;
  logic                           st_err;
  logic                           done;
  logic [incl_chk_pkg::QtyW-1:0]  qty;

  incl_chk_crc u_crc (
    .msg_i (frame_i[incl_chk_pkg::FrameW-1:incl_chk_pkg::CrcW]),
    .crc_o (crc_calc)
  );

  // Field extraction and per-frame checks.
  assign op      = frame_i[incl_chk_pkg::FrameW-1 -: incl_chk_pkg::OpW];
  assign data    = frame_i[incl_chk_pkg::CrcW +: incl_chk_pkg::DataW];
  assign crc_err = (crc_calc != frame_i[incl_chk_pkg::CrcW-1:0]);
  assign st_err  = (op[1:0] != incl_chk_pkg::StatusOk);

  // Position of this frame within the burst; zero outside a burst.
  always_comb begin
    if (start_i) begin
      pos = PosOne;
    end else if (pos_q >= PosOne && pos_q < LastPos) begin
      pos = pos_q + PosOne;
    end else begin
      pos = '0;
    end
  end

  assign done    = (pos == LastPos);
  assign pos_off = pos - PosTwo;

  // Quantity carried by the response at this position.
  always_comb begin
    priority if (pos < 4'd3) begin
      qty = incl_chk_pkg::QtyNone;
    end else if (pos == LastPos) begin
      qty = incl_chk_pkg::QtyId;
    end else if (pos == PrevPos) begin
      qty = incl_chk_pkg::QtyStatus;
    end else if (pos_off <= incl_chk_pkg::QtyLastRun) begin
      qty = incl_chk_pkg::QtyW'(pos_off);
    end else begin
      qty = incl_chk_pkg::QtyNone;
    end
  end

  // Burst state after this frame.
  always_comb begin
    berr_d = berr_q;
    pos_d  = pos_q;
    if (pos == PosOne) begin
      berr_d = 1'b0;
    end else if (pos >= PosTwo) begin
      berr_d = berr_q | crc_err | st_err;
    end
    if (done) begin
      pos_d = '0;
    end else if (pos != '0) begin
      pos_d = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      berr_q <= 1'b0;
    end else if (advance_i) begin
      pos_q  <= pos_d;
      berr_q <= berr_d;
    end
  end

  // Result of the frame.
  always_comb begin
    result_o.quantity     = qty;
    result_o.data_word    = data;
    result_o.op_byte      = op;
    result_o.crc_error    = crc_err;
    result_o.status_error = st_err;
    result_o.burst_done   = done;
    result_o.burst_ok     = done && !berr_d && (data == expected_id_i);
  end

endmodule

### design/inclinometer_spi_response_checker_top.sv
// Channel   | Direction | Transaction contents
// ----------+-----------+-------------------------------------------------------
// rx_i      | in        | rx_frame, burst_start
// res_o     | out       | quantity, data_word, op_byte, crc/status errors, burst flags
// cfg       | in        | cfg_we_i / cfg_wdata_i write expected_id
//
// One frame is accepted per cycle unless the result side stalls; its result goes through
// the input register, then the result register, and is valid once that register loads.
// The CRC network and position logic sit between those two registers.
// Reset clears the burst position, the error flag, both valid bits and sets expected_id.
// A stalled result holds its register; a new frame is still taken while the input
// register is empty or moving on.
module inclinometer_spi_response_checker_top #(
  parameter int FRAMES_PER_BURST = incl_chk_pkg::FramesPerBurstDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [incl_chk_pkg::DataW-1:0] cfg_wdata_i,
  incl_frame_if.sink                     rx_i,
  incl_result_if.source                  res_o
);

  logic                           in_valid_q;
  logic [incl_chk_pkg::FrameW-1:0] frame_q;
  logic                           start_q;
  logic                           out_valid_q;
  incl_chk_pkg::result_t          res_q;
  incl_chk_pkg::result_t          res_d;
  logic [incl_chk_pkg::DataW-1:0] expected_id_q;
  logic                           advance;
  logic                           take;

  // Pipeline handshake.
  assign advance  = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign take     = rx_i.valid && rx_i.ready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= incl_chk_pkg::ExpectedIdReset;
    end else if (cfg_we_i) begin
      expected_id_q <= cfg_wdata_i;
    end
  end

  // Input register valid and control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      frame_q <= rx_i.rx_frame;
      start_q <= rx_i.burst_start;
    end
  end

  incl_chk_core #(
    .FRAMES_PER_BURST (FRAMES_PER_BURST)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .frame_i       (frame_q),
    .start_i       (start_q),
    .expected_id_i (expected_id_q),
    .result_o      (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.quantity     = res_q.quantity;
  assign res_o.data_word    = res_q.data_word;
  assign res_o.op_byte      = res_q.op_byte;
  assign res_o.crc_error    = res_q.crc_error;
  assign res_o.status_error = res_q.status_error;
  assign res_o.burst_done   = res_q.burst_done;
  assign res_o.burst_ok     = res_q.burst_ok;

endmodule

### verif/incl_response_checker.sv
package incl_crc_tb_pkg;
  import incl_chk_pkg::*;

  // CRC-8 over the op byte and data field, MSB first, inverted at the end.
  function automatic logic [CrcW-1:0] frame_crc8(input logic [FrameW-1:0] frame);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = CrcInit;
    for (int b = FrameW - 1; b >= CrcW; b--) begin
      fb  = crc[CrcW-1] ^ frame[b];
      crc = {crc[CrcW-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return ~crc;
  endfunction

endpackage

module incl_response_checker #(
  parameter int FRAMES_PER_BURST = incl_chk_pkg::FramesPerBurstDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [incl_chk_pkg::DataW-1:0] cfg_wdata_i,
  incl_frame_if                          rx_i,
  incl_result_if                         res_i,
  output int                             mismatch_count_o,
  output int                             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import incl_chk_pkg::*;
  import incl_crc_tb_pkg::*;

  // Shadow copy of the burst tracker and the identity register.
  logic [PosW-1:0]  burst_pos;
  logic             burst_err;
  logic [DataW-1:0] id_reg;
  result_t          response_q[$];
  int               fails;

  // Quantity named by a position within the burst.
  function automatic logic [QtyW-1:0] quantity_at(input int pos);
    if (pos < 3) begin
      return QtyNone;
    end
    if (pos == FRAMES_PER_BURST) begin
      return QtyId;
    end
    if (pos == FRAMES_PER_BURST - 1) begin
      return QtyStatus;
    end
    if (pos - 2 <= int'(QtyLastRun)) begin
      return QtyW'(pos - 2);
    end
    return QtyNone;
  endfunction

  // Checks one frame, advances the burst tracker and returns the response it should give.
  function automatic result_t predict_response(input logic [FrameW-1:0] frame,
                                               input logic start);
    result_t r;
    int      pos;
    r.op_byte      = frame[FrameW-1 -: OpW];
    r.data_word    = frame[CrcW +: DataW];
    r.crc_error    = frame_crc8(frame) != frame[CrcW-1:0];
    r.status_error = r.op_byte[1:0] != StatusOk;
    r.burst_done   = 1'b0;
    r.burst_ok     = 1'b0;

    if (start) begin
      pos = 1;
    end else if (burst_pos >= 1 && burst_pos < FRAMES_PER_BURST) begin
      pos = int'(burst_pos) + 1;
    end else begin
      pos = 0;
    end

    // Errors count from the second frame on; the first frame only reports them.
    if (pos == 1) begin
      burst_err = 1'b0;
    end else if (pos >= 2) begin
      burst_err = burst_err | r.crc_error | r.status_error;
    end

    if (pos == FRAMES_PER_BURST) begin
      r.burst_done = 1'b1;
      r.burst_ok   = !burst_err && (r.data_word == id_reg);
      burst_pos    = '0;
    end else if (pos != 0) begin
      burst_pos = PosW'(pos);
    end

    r.quantity = quantity_at(pos);
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Results are compared before the new frame is queued, so a stray result
  // can never match a frame taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      burst_pos = '0;
      burst_err = 1'b0;
      id_reg    = ExpectedIdReset;
      fails     = 0;
      response_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (response_q.size() == 0) begin
          fails++;
          $display("%0t: result transaction with none expected, actual data_word 0x%0h op_byte 0x%0h",
                   $time, res_i.data_word, res_i.op_byte);
        end else begin
          want = response_q.pop_front();
          compare_field("quantity", want.quantity, res_i.quantity);
          compare_field("data_word", want.data_word, res_i.data_word);
          compare_field("op_byte", want.op_byte, res_i.op_byte);
          compare_field("crc_error", want.crc_error, res_i.crc_error);
          compare_field("status_error", want.status_error, res_i.status_error);
          compare_field("burst_done", want.burst_done, res_i.burst_done);
          compare_field("burst_ok", want.burst_ok, res_i.burst_ok);
        end
      end
      if (rx_i.valid && rx_i.ready) begin
        response_q.push_back(predict_response(rx_i.rx_frame, rx_i.burst_start));
      end
      if (cfg_we_i) begin
        id_reg = cfg_wdata_i;
      end
    end
    mismatch_count_o <= fails;
    outstanding_o    <= response_q.size();
  end

endmodule

### verif/tb_inclinometer_spi_response_checker_top.sv
module tb_inclinometer_spi_response_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import incl_chk_pkg::*;
  import incl_crc_tb_pkg::*;

  localparam int BurstLen   = FramesPerBurstDefault;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 130;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DataW-1:0] cfg_wdata_i;

  incl_frame_if  rx_if ();
  incl_result_if res_if ();

  int               mismatches;
  int               outstanding;
  int               frames_sent  = 0;
  int               stall_cycles = 0;
  int               tx_calm      = 0;
  int               rx_calm      = 0;
  logic [DataW-1:0] id_now;

  inclinometer_spi_response_checker_top #(
    .FRAMES_PER_BURST(BurstLen)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  incl_response_checker #(
    .FRAMES_PER_BURST(BurstLen)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_i             (rx_if),
    .res_i            (res_if),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Wait before a transaction: a random gap, with occasional stretches of none.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Well-formed response: good status code and matching CRC.
  function automatic logic [FrameW-1:0] clean_frame(input logic [DataW-1:0] data);
    logic [OpW-1:0]    op;
    logic [FrameW-1:0] frame;
    op              = OpW'($urandom);
    op[1:0]         = StatusOk;
    frame           = {op, data, CrcW'(0)};
    frame[CrcW-1:0] = frame_crc8(frame);
    return frame;
  endfunction

  // Damages a frame: a flipped bit, a bad status code, or a random CRC byte.
  function automatic logic [FrameW-1:0] spoil_frame(input logic [FrameW-1:0] frame);
    logic [1:0] st;
    int         flip;
    flip = $urandom_range(0, FrameW - 1);
    case ($urandom_range(0, 2))
      0: begin
        frame[flip] = ~frame[flip];
      end
      1: begin
        do st = 2'($urandom); while (st == StatusOk);
        frame[CrcW+DataW +: 2] = st;
        frame[CrcW-1:0]        = frame_crc8(frame);
      end
      default: begin
        frame[CrcW-1:0] = CrcW'($urandom);
      end
    endcase
    return frame;
  endfunction

  // Offers one frame and holds it until the block takes it.
  task automatic push_frame(input logic [FrameW-1:0] frame, input logic start);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid       <= 1'b1;
    rx_if.rx_frame    <= frame;
    rx_if.burst_start <= start;
    do @(posedge clk_i); while (!rx_if.ready);
    frames_sent++;
  endtask

  // A burst of len frames; in a full-length burst the last one carries the identity most of the time.
  task automatic send_burst(input int len);
    logic [DataW-1:0]  data;
    logic [FrameW-1:0] frame;
    for (int p = 1; p <= len; p++) begin
      if (p == BurstLen && $urandom_range(0, 3) != 0) begin
        data = id_now;
      end else begin
        data = DataW'($urandom);
      end
      frame = clean_frame(data);
      if ($urandom_range(0, 24) == 0) begin
        frame = spoil_frame(frame);
      end
      push_frame(frame, p == 1);
    end
  endtask

  // Holds off the sender until every response is back and the pipeline is empty.
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_id(input logic [DataW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    id_now = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly complete bursts, some cut short or restarted, some stray frames.
  task automatic random_phase(input int count);
    int goal;
    goal = frames_sent + count;
    while (frames_sent < goal) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            push_frame($urandom_range(0, 1) ? FrameW'($urandom) : clean_frame(DataW'($urandom)),
                       $urandom_range(0, 7) == 0);
          end
        end
        1: begin
          send_burst($urandom_range(1, BurstLen - 1));
        end
        default: begin
          send_burst(BurstLen);
        end
      endcase
    end
  endtask

  // Result side: ready may drop for a random number of cycles before each transaction.
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_wait(rx_calm);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [FrameW-1:0] frame;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    rx_if.valid       <= 1'b0;
    rx_if.rx_frame    <= '0;
    rx_if.burst_start <= 1'b0;
    id_now = ExpectedIdReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Frames outside any burst, at the extremes of the frame field.
    push_frame('0, 1'b0);
    push_frame('1, 1'b0);
    push_frame(clean_frame('0), 1'b0);
    push_frame(clean_frame('1), 1'b0);

    // Full burst whose first frame is bad: it must not spoil the result.
    for (int p = 1; p <= BurstLen; p++) begin
      frame = clean_frame((p == BurstLen) ? id_now : DataW'($urandom));
      if (p == 1) begin
        frame[CrcW+DataW +: 2] = ~StatusOk;
        frame[CrcW-1:0]        = ~frame[CrcW-1:0];
      end
      push_frame(frame, p == 1);
    end

    // A burst cut short and restarted by the next one.
    send_burst(4);
    wait_drained();

    // Random phases under several identity settings.
    random_phase(PhaseItems);
    write_id('0);
    random_phase(PhaseItems);
    write_id('1);
    random_phase(PhaseItems);
    write_id(DataW'($urandom));
    random_phase(PhaseItems);
    write_id(ExpectedIdReset);
    random_phase(PhaseItems);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Ends the run when no transaction has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
